/* hw/rtl/luma_sine_wave_modulator_macros.svh */
// assertion macros for the luma sine wave modulator
`ifndef LUMA_SINE_WAVE_MODULATOR_MACROS_SVH
`define LUMA_SINE_WAVE_MODULATOR_MACROS_SVH

// same-cycle implication on the block clock
`define LSWM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock
`define LSWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/lswm_pkg.sv */
// types, constants and sine table for the luma sine wave modulator
`timescale 1ns / 1ps
`default_nettype none
package lswm_pkg;

   localparam int PIX_W   = 8;
   localparam int DIM_W   = 13;
   localparam int ROW_W   = 12;
   localparam int Y_W     = 14;
   localparam int SPD_W   = 20;
   localparam int PH_W    = 32;
   localparam int TRIG_W  = 16;
   localparam int ACC_W   = 56;
   localparam int DIV_W   = 20;
   localparam int DVS_W   = 13;
   localparam int IDX_W   = 10;
   localparam int WAVE_W  = 17;
   localparam int REQ_W   = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [17:0] PHASE_K    = 18'd106807;
   localparam logic [16:0] ANG_RECIP  = 17'd93207;
   localparam logic [7:0]  LUMA_LO    = 8'd16;
   localparam logic [7:0]  LUMA_HI    = 8'd235;
   localparam longint      PI_Q30     = 64'sd3373259426;

   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BREAK     = 3'd6;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_ANGLE,
      OP_MAX,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_SPEED,
      OP_ROWSPD,
      OP_INC_A,
      OP_INC_B,
      OP_INC_W,
      OP_ROW_A,
      OP_ROW_B,
      OP_ROW_HI,
      OP_ROW_LO,
      OP_ROW_W,
      OP_PIX_A,
      OP_PIX_B
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_MAX,
      ST_DIV_INIT,
      ST_DIV,
      ST_SPEED,
      ST_ROWSPD,
      ST_INC_A,
      ST_INC_B,
      ST_INC_W,
      ST_ROW_A,
      ST_ROW_B,
      ST_ROW_HI,
      ST_ROW_LO,
      ST_ROW_W,
      ST_PIX_A,
      ST_PIX_B
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      sel_x;
   } ctl_cmd_type;

   typedef struct packed {
      logic row_end;
      logic out_free;
   } dp_status_type;

   typedef logic [14:0] qtab_type [0:256];

   // shift-subtract quotient of two non-negative values, table build only
   function automatic longint div_pos(input longint num, input longint den);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         r = (r <<< 1) | ((num >>> b) & 64'sd1);
         q = q <<< 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'sd1;
         end
      end
      return q;
   endfunction

   function automatic int quarter_sine(input int k);
      longint x;
      longint x2;
      longint term;
      longint sum;
      if (k == 0) return 0;
      if (k >= 256) return 16384;
      x = (PI_Q30 * longint'(k) + 64'sd256) >>> 9;
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 10; n++) begin
         term = div_pos((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
         sum = ((n & 1) == 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      return int'((sum * 64'sd16384) >>> 30);
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int k = 0; k <= 256; k++) begin
         t[k] = 15'(quarter_sine(k));
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [IDX_W-1:0] idx);
      logic [8:0]  ri;
      logic [14:0] mag;
      ri = idx[8] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
      mag = QTAB[ri];
      return idx[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/luma_sine_wave_modulator.sv */
// top level of the luma sine wave modulator
//
//   channel  direction  beat contents
//   req_     in         tuser: command; tdata: width, height, first row, luma
//   rsp_     out        tdata: modulated luma
//   csr_     in         register index and write data, one write per cycle
//
// pixel beat inside a row: the accept, sine-sum and output steps
// pixel beat closing a row: then the two row phase reloads on the shared multiplier
// frame-start beat: angles, max size, bit-serial speed divider, increments, row reloads
// sync reset restores default register values and zero state, not the working registers
// a held result waits in the output register; the next beat is taken meanwhile
`timescale 1ns / 1ps
`default_nettype none
`include "luma_sine_wave_modulator_macros.svh"
module luma_sine_wave_modulator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // width [12:0], height [25:13], first_row [37:26], pixel_luma [45:38], zero pad
   input  wire logic [lswm_pkg::REQ_W-1:0]            req_tdata,
   // command [0]
   input  wire logic                                  req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // out_luma [7:0]
   output logic [lswm_pkg::PIX_W-1:0]                 rsp_tdata,
   input  wire logic                                  csr_wen,
   input  wire logic [lswm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [lswm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lswm_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   lswm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lswm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `LSWM_ASSERT_SAME(a_out_free, cmd.op == OP_PIX_B, status.out_free, "result overwrites pending beat")
   `LSWM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "beat taken while busy")
   `LSWM_ASSERT_SAME(a_luma_range, rsp_tvalid, (rsp_tdata == LUMA_LO) || (rsp_tdata == LUMA_HI) || (rsp_tdata > LUMA_LO && rsp_tdata < LUMA_HI), "luma outside limits")

endmodule
`default_nettype wire

/* hw/rtl/lswm_ctrl.sv */
// sequencer for frame setup, row phase reload and pixel beats
`timescale 1ns / 1ps
`default_nettype none
module lswm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tuser,
   output logic                       req_tready,
   input  wire lswm_pkg::dp_status_type status,
   output lswm_pkg::ctl_cmd_type      cmd
);
   import lswm_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          x_ff, x_in;
   logic [4:0]    cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         x_ff     <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         x_ff     <= x_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.sel_x  = x_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_ACCEPT;
               if (req_tuser == CMD_FRAME) begin
                  x_in     = 1'b1;
                  state_in = ST_ANGLE;
               end else begin
                  state_in = ST_PIX_A;
               end
            end
         end
         ST_ANGLE: begin
            cmd.op = OP_ANGLE;
            x_in   = 1'b0;
            if (!x_ff) state_in = ST_MAX;
         end
         ST_MAX: begin
            cmd.op   = OP_MAX;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_W - 1)) state_in = ST_SPEED;
         end
         ST_SPEED: begin
            cmd.op   = OP_SPEED;
            state_in = ST_ROWSPD;
         end
         ST_ROWSPD: begin
            cmd.op   = OP_ROWSPD;
            x_in     = 1'b0;
            state_in = ST_INC_A;
         end
         ST_INC_A: begin
            cmd.op   = OP_INC_A;
            state_in = ST_INC_B;
         end
         ST_INC_B: begin
            cmd.op   = OP_INC_B;
            state_in = ST_INC_W;
         end
         ST_INC_W: begin
            cmd.op = OP_INC_W;
            x_in   = !x_ff;
            state_in = x_ff ? ST_ROW_A : ST_INC_A;
         end
         ST_ROW_A: begin
            cmd.op   = OP_ROW_A;
            state_in = ST_ROW_B;
         end
         ST_ROW_B: begin
            cmd.op   = OP_ROW_B;
            state_in = ST_ROW_HI;
         end
         ST_ROW_HI: begin
            cmd.op   = OP_ROW_HI;
            state_in = ST_ROW_LO;
         end
         ST_ROW_LO: begin
            cmd.op   = OP_ROW_LO;
            state_in = ST_ROW_W;
         end
         ST_ROW_W: begin
            cmd.op = OP_ROW_W;
            x_in   = !x_ff;
            state_in = x_ff ? ST_IDLE : ST_ROW_A;
         end
         ST_PIX_A: begin
            cmd.op   = OP_PIX_A;
            state_in = ST_PIX_B;
         end
         ST_PIX_B: begin
            if (status.out_free) begin
               cmd.op = OP_PIX_B;
               if (status.row_end) begin
                  x_in     = 1'b0;
                  state_in = ST_ROW_A;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/lswm_datapath.sv */
// registers, shared multiplier, divider and pixel arithmetic
`timescale 1ns / 1ps
`default_nettype none
module lswm_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [lswm_pkg::REQ_W-1:0]            req_tdata,
   input  wire logic                                  req_tuser,
   input  wire logic                                  csr_wen,
   input  wire logic [lswm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [lswm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire lswm_pkg::ctl_cmd_type                 cmd,
   output lswm_pkg::dp_status_type                    status,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [lswm_pkg::PIX_W-1:0]                 rsp_tdata
);
   import lswm_pkg::*;

   logic [6:0] freq_x_ff, freq_x_in, freq_y_ff, freq_y_in, min_speed_ff, min_speed_in;
   logic [5:0] amplitude_ff, amplitude_in;
   logic [8:0] angle_x_ff, angle_x_in, angle_y_ff, angle_y_in, break_ff, break_in;

   logic [DIM_W-1:0]  wid_ff, wid_in, hgt_ff, hgt_in, col_ff, col_in, row_ff, row_in;
   logic [ROW_W-1:0]  first_ff, first_in;
   logic [6:0]        fx_ff, fx_in, fy_ff, fy_in;
   logic [5:0]        amp_ff, amp_in;
   logic [IDX_W-1:0]  idx_x_ff, idx_x_in, idx_y_ff, idx_y_in;
   logic [SPD_W-1:0]  accum_ff, accum_in, rps_ff, rps_in, maxs_ff, maxs_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in, rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [PH_W-1:0]   inc_x_ff, inc_x_in, inc_y_ff, inc_y_in;
   logic [PH_W-1:0]   ph_x_ff, ph_x_in, ph_y_ff, ph_y_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [17:0]       lo_ff, lo_in;
   logic [PIX_W-1:0]  pix_ff, pix_in, out_ff, out_in;
   logic signed [WAVE_W-1:0] wave_ff, wave_in;
   logic              vld_ff, vld_in;

   logic [6:0]              f_sel;
   logic signed [TRIG_W-1:0] trig_inc, trig_row;
   logic signed [TRIG_W-1:0] sin_ph_x, sin_ph_y;
   logic [Y_W-1:0]          y_val;
   logic signed [24:0]      mul_a;
   logic signed [17:0]      mul_b;
   logic signed [42:0]      prod;
   logic signed [ACC_W-1:0] prod_ext, acc_rnd;
   logic [PH_W-1:0]         q32;
   logic [8:0]              deg;
   logic [32:0]             ang_prod;
   logic [SPD_W-1:0]        mx, my;
   logic [8:0]              brk;
   logic [14:0]             diff;
   logic [SPD_W-1:0]        step;
   logic [SPD_W:0]          sum;
   logic [DIM_W-1:0]        wl, hl;
   logic [DIM_W:0]          col_next, row_next;
   logic signed [23:0]      v;
   logic signed [9:0]       off;
   logic signed [10:0]      luma;

   assign f_sel    = cmd.sel_x ? fx_ff : fy_ff;
   assign trig_inc = cmd.sel_x ? sine_q14(idx_x_ff + 10'd256) : sine_q14(idx_x_ff);
   assign trig_row = cmd.sel_x ? sine_q14(idx_y_ff) : sine_q14(idx_y_ff + 10'd256);
   assign sin_ph_y = sine_q14(ph_y_ff[25:16]);
   assign sin_ph_x = sine_q14(ph_x_ff[25:16]);
   assign y_val    = {2'b00, first_ff} + {1'b0, row_ff};
   assign prod     = mul_a * mul_b;
   assign prod_ext = {{(ACC_W - 43){prod[42]}}, prod};
   assign acc_rnd  = acc_ff + (acc_ff[ACC_W-1] ? 56'sd16383 : 56'sd0);
   assign q32      = acc_rnd[45:14];
   assign deg      = cmd.sel_x ? angle_x_ff : angle_y_ff;
   assign ang_prod = {1'b0, deg, 7'b0} * ANG_RECIP;
   assign mx       = {13'b0, fx_ff} * {7'b0, wid_ff};
   assign my       = {13'b0, fy_ff} * {7'b0, hgt_ff};
   assign brk      = (break_ff == 9'd0) ? 9'd1 : break_ff;
   assign diff     = {1'b0, rem_ff, quo_ff[DIV_W-1]} - {2'b00, dvs_ff};
   assign step     = (quo_ff == '0) ? 20'd1 : quo_ff;
   assign sum      = {1'b0, accum_ff} + {1'b0, step};
   assign wl       = (wid_ff == '0) ? 13'd1 : wid_ff;
   assign hl       = (hgt_ff == '0) ? 13'd1 : hgt_ff;
   assign col_next = {1'b0, col_ff} + 14'd1;
   assign row_next = {1'b0, row_ff} + 14'd1;
   assign v        = $signed({1'b0, amp_ff}) * wave_ff
                   + (wave_ff[WAVE_W-1] ? -24'sd8192 : 24'sd8192);
   assign off      = v[23:14];
   assign luma     = $signed({3'b000, pix_ff}) + {off[9], off};

   assign status.row_end  = col_next >= {1'b0, wl};
   assign status.out_free = !vld_ff || rsp_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_INC_A: begin
            mul_a = {18'b0, f_sel};
            mul_b = {{2{trig_inc[TRIG_W-1]}}, trig_inc};
         end
         OP_INC_B: begin
            mul_a = acc_ff[24:0];
            mul_b = PHASE_K;
         end
         OP_ROW_A: begin
            mul_a = {18'b0, f_sel};
            mul_b = {4'b0, y_val};
         end
         OP_ROW_B: begin
            mul_a = acc_ff[24:0];
            mul_b = {{2{trig_row[TRIG_W-1]}}, trig_row};
         end
         OP_ROW_HI: begin
            mul_a = acc_ff[42:18];
            mul_b = PHASE_K;
         end
         OP_ROW_LO: begin
            mul_a = {7'b0, lo_ff};
            mul_b = PHASE_K;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      freq_x_in = freq_x_ff;  freq_y_in = freq_y_ff;  amplitude_in = amplitude_ff;
      min_speed_in = min_speed_ff;  angle_x_in = angle_x_ff;  angle_y_in = angle_y_ff;
      break_in = break_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_FREQ_X:    freq_x_in    = csr_wdata[6:0];
            CSR_FREQ_Y:    freq_y_in    = csr_wdata[6:0];
            CSR_AMPLITUDE: amplitude_in = csr_wdata[5:0];
            CSR_MIN_SPEED: min_speed_in = csr_wdata[6:0];
            CSR_ANGLE_X:   angle_x_in   = csr_wdata;
            CSR_ANGLE_Y:   angle_y_in   = csr_wdata;
            CSR_BREAK:     break_in     = csr_wdata;
            default:       break_in     = break_ff;
         endcase
      end
   end

   always_comb begin
      wid_ff_hold: begin
         wid_in = wid_ff;  hgt_in = hgt_ff;  first_in = first_ff;
         fx_in = fx_ff;  fy_in = fy_ff;  amp_in = amp_ff;
         idx_x_in = idx_x_ff;  idx_y_in = idx_y_ff;
         accum_in = accum_ff;  rps_in = rps_ff;  maxs_in = maxs_ff;
         dvs_in = dvs_ff;  rem_in = rem_ff;  quo_in = quo_ff;
         inc_x_in = inc_x_ff;  inc_y_in = inc_y_ff;
         ph_x_in = ph_x_ff;  ph_y_in = ph_y_ff;
         acc_in = acc_ff;  lo_in = lo_ff;
         col_in = col_ff;  row_in = row_ff;
         pix_in = pix_ff;  wave_in = wave_ff;  out_in = out_ff;
         vld_in = vld_ff && !rsp_tready;
      end
      case (cmd.op)
         OP_ACCEPT: begin
            pix_in = req_tdata[45:38];
            if (req_tuser == CMD_FRAME) begin
               wid_in   = req_tdata[12:0];
               hgt_in   = req_tdata[25:13];
               first_in = req_tdata[37:26];
               fx_in    = freq_x_ff;
               fy_in    = freq_y_ff;
               amp_in   = amplitude_ff;
               col_in   = '0;
               row_in   = '0;
            end
         end
         OP_ANGLE: begin
            if (cmd.sel_x) idx_x_in = ang_prod[31:22];
            else           idx_y_in = ang_prod[31:22];
         end
         OP_MAX: begin
            maxs_in = (mx > my) ? mx : my;
         end
         OP_DIV_INIT: begin
            dvs_in = 13'({brk, 3'b000}) + 13'({brk, 1'b0});
            rem_in = '0;
            quo_in = maxs_ff;
         end
         OP_DIV_STEP: begin
            if (!diff[14]) begin
               rem_in = diff[12:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[11:0], quo_ff[DIV_W-1]};
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         OP_SPEED: begin
            accum_in = (sum > {1'b0, maxs_ff}) ? {13'b0, min_speed_ff} : sum[SPD_W-1:0];
         end
         OP_ROWSPD: begin
            rps_in = {13'b0, min_speed_ff} + accum_ff;
         end
         OP_INC_A, OP_INC_B, OP_ROW_A: begin
            acc_in = prod_ext;
         end
         OP_INC_W: begin
            if (cmd.sel_x) inc_x_in = q32;
            else           inc_y_in = q32;
         end
         OP_ROW_B: begin
            acc_in = prod_ext + {22'b0, rps_ff, 14'b0};
         end
         OP_ROW_HI: begin
            lo_in  = acc_ff[17:0];
            acc_in = {prod_ext[37:0], 18'b0};
         end
         OP_ROW_LO: begin
            acc_in = acc_ff + prod_ext;
         end
         OP_ROW_W: begin
            if (cmd.sel_x) ph_x_in = q32;
            else           ph_y_in = q32;
         end
         OP_PIX_A: begin
            wave_in = {sin_ph_y[TRIG_W-1], sin_ph_y} + {sin_ph_x[TRIG_W-1], sin_ph_x};
         end
         OP_PIX_B: begin
            vld_in = 1'b1;
            if (luma < $signed({3'b000, LUMA_LO}))      out_in = LUMA_LO;
            else if (luma > $signed({3'b000, LUMA_HI})) out_in = LUMA_HI;
            else                                        out_in = luma[7:0];
            if (status.row_end) begin
               col_in = '0;
               row_in = (row_next >= {1'b0, hl}) ? '0 : row_next[DIM_W-1:0];
            end else begin
               col_in  = col_next[DIM_W-1:0];
               ph_x_in = ph_x_ff + inc_x_ff;
               ph_y_in = ph_y_ff + inc_y_ff;
            end
         end
         default: begin
            lo_in = lo_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_x_ff <= 7'd4;  freq_y_ff <= 7'd5;  amplitude_ff <= 6'd30;
         min_speed_ff <= 7'd10;  angle_x_ff <= 9'd33;  angle_y_ff <= 9'd10;
         break_ff <= 9'd100;
         wid_ff <= '0;  hgt_ff <= '0;  first_ff <= '0;
         fx_ff <= '0;  fy_ff <= '0;  amp_ff <= '0;
         idx_x_ff <= '0;  idx_y_ff <= '0;
         accum_ff <= '0;  rps_ff <= '0;
         inc_x_ff <= '0;  inc_y_ff <= '0;  ph_x_ff <= '0;  ph_y_ff <= '0;
         col_ff <= '0;  row_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         freq_x_ff <= freq_x_in;  freq_y_ff <= freq_y_in;  amplitude_ff <= amplitude_in;
         min_speed_ff <= min_speed_in;  angle_x_ff <= angle_x_in;  angle_y_ff <= angle_y_in;
         break_ff <= break_in;
         wid_ff <= wid_in;  hgt_ff <= hgt_in;  first_ff <= first_in;
         fx_ff <= fx_in;  fy_ff <= fy_in;  amp_ff <= amp_in;
         idx_x_ff <= idx_x_in;  idx_y_ff <= idx_y_in;
         accum_ff <= accum_in;  rps_ff <= rps_in;
         inc_x_ff <= inc_x_in;  inc_y_ff <= inc_y_in;  ph_x_ff <= ph_x_in;  ph_y_ff <= ph_y_in;
         col_ff <= col_in;  row_ff <= row_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      maxs_ff <= maxs_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      acc_ff  <= acc_in;
      lo_ff   <= lo_in;
      pix_ff  <= pix_in;
      wave_ff <= wave_in;
      out_ff  <= out_in;
   end

endmodule
`default_nettype wire

/* bench/luma_sine_wave_checker.sv */
// checker for the luma sine wave modulator: predicts output luma and compares beats
`timescale 1ns / 1ps
module luma_sine_wave_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_index,
   input  wire logic [8:0]  csr_wdata,
   output int               fail_count,
   output int               pending
);
   import lswm_pkg::*;

   logic signed [15:0] sin_tab [0:1023];
   logic [7:0] luma_q [$];

   logic [31:0] c_fx, c_fy, c_amp, c_mins, c_ax, c_ay, c_brk;
   logic [31:0] spd_acc, row_spd, inc_x, inc_y, acc_x, acc_y, col_cnt, row_cnt;
   logic [31:0] l_w, l_h, l_first, l_fx, l_fy, l_amp;
   int l_sy, l_cy;

   function automatic longint sin_q14(input int k);
      longint x, x2, term, sum;
      if (k == 0) return 0;
      if (k >= 256) return 16384;
      x = (longint'(PI_Q30) * k + 256) / 512;
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 10; n++) begin
         term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
         sum = (n & 1) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      return (sum * 16384) >>> 30;
   endfunction

   function automatic logic [31:0] row_base(input logic [31:0] f, input logic [31:0] y,
                                            input int trig, input logic [31:0] spd);
      longint t;
      t = longint'(f) * longint'(y) * longint'(trig) + longint'(spd) * 16384;
      t = t * 106807 / 16384;
      return t[31:0];
   endfunction

   task automatic reload_row();
      logic [31:0] y;
      y = l_first + row_cnt;
      acc_y = row_base(l_fy, y, l_cy, row_spd);
      acc_x = row_base(l_fx, y, l_sy, row_spd);
   endtask

   task automatic take_beat(input logic cmd, input logic [47:0] d);
      logic [31:0] w, h, ax, ay, mx, my, mxs, brk, stp, wl, hl;
      longint t;
      int wave, v, off, luma;
      if (cmd == CMD_FRAME) begin
         w = d[12:0];
         h = d[25:13];
         ax = ((c_ax * 1024) / 360) & 1023;
         ay = ((c_ay * 1024) / 360) & 1023;
         mx = c_fx * w;
         my = c_fy * h;
         mxs = mx > my ? mx : my;
         brk = c_brk ? c_brk : 1;
         stp = mxs / (brk * 10);
         if (stp < 1) stp = 1;
         spd_acc = spd_acc + stp;
         if (spd_acc > mxs) spd_acc = c_mins;
         row_spd = c_mins + spd_acc;
         l_w = w;
         l_h = h;
         l_first = d[37:26];
         l_fx = c_fx;
         l_fy = c_fy;
         l_amp = c_amp;
         l_sy = sin_tab[ay];
         l_cy = sin_tab[(ay + 256) & 1023];
         t = longint'(c_fy) * longint'(sin_tab[ax]) * 106807 / 16384;
         inc_y = t[31:0];
         t = longint'(c_fx) * longint'(sin_tab[(ax + 256) & 1023]) * 106807 / 16384;
         inc_x = t[31:0];
         col_cnt = 0;
         row_cnt = 0;
         reload_row();
      end else begin
         wave = int'(sin_tab[acc_y[25:16]]) + int'(sin_tab[acc_x[25:16]]);
         v = int'(l_amp) * wave + (wave >= 0 ? 8192 : -8192);
         off = v >= 0 ? (v >>> 14) : -((-v + 16383) >>> 14);
         luma = int'(d[45:38]) + off;
         if (luma < int'(LUMA_LO)) luma = LUMA_LO;
         else if (luma > int'(LUMA_HI)) luma = LUMA_HI;
         luma_q.push_back(luma[7:0]);
         wl = l_w ? l_w : 1;
         hl = l_h ? l_h : 1;
         col_cnt++;
         if (col_cnt >= wl) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= hl) row_cnt = 0;
            reload_row();
         end else begin
            acc_x = acc_x + inc_x;
            acc_y = acc_y + inc_y;
         end
      end
   endtask

   initial begin
      int q, r, m;
      for (int i = 0; i < 1024; i++) begin
         q = (i >> 8) & 3;
         r = i & 255;
         m = (q & 1) ? int'(sin_q14(256 - r)) : int'(sin_q14(r));
         sin_tab[i] = (q & 2) ? -m : m;
      end
   end

   assign pending = luma_q.size();

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         c_fx <= 4; c_fy <= 5; c_amp <= 30; c_mins <= 10;
         c_ax <= 33; c_ay <= 10; c_brk <= 100;
         spd_acc = 0; row_spd = 0; inc_x = 0; inc_y = 0; acc_x = 0; acc_y = 0;
         col_cnt = 0; row_cnt = 0;
         l_w = 0; l_h = 0; l_first = 0; l_fx = 0; l_fy = 0; l_amp = 0;
         l_sy = 0; l_cy = 0;
         luma_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_FREQ_X:    c_fx <= csr_wdata[6:0];
               CSR_FREQ_Y:    c_fy <= csr_wdata[6:0];
               CSR_AMPLITUDE: c_amp <= csr_wdata[5:0];
               CSR_MIN_SPEED: c_mins <= csr_wdata[6:0];
               CSR_ANGLE_X:   c_ax <= csr_wdata;
               CSR_ANGLE_Y:   c_ay <= csr_wdata;
               CSR_BREAK:     c_brk <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (luma_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected output beat %0d", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = luma_q.pop_front();
               if (want !== rsp_tdata) begin
                  if (fail_count < 10)
                     $display("out_luma mismatch: expected %0d, got %0d", want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) take_beat(req_tuser, req_tdata);
      end
   end
endmodule

/* bench/tb_top.sv */
// testbench top for the luma sine wave modulator: stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb_top;
   import lswm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tuser = 0, rsp_tready = 0, csr_wen = 0;
   logic req_tready, rsp_tvalid;
   logic [47:0] req_tdata = '0;
   logic [7:0] rsp_tdata;
   logic [2:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;
   int fail_count, pending;
   int idle_cycles = 0;
   bit timed_out = 0;

   luma_sine_wave_modulator dut (.*);
   luma_sine_wave_checker chk (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000 && !timed_out) begin
         timed_out = 1;
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // receiver stalls
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
         if (gap != 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_beat(input logic cmd, input logic [12:0] w, input logic [12:0] h,
                            input logic [11:0] fr, input logic [7:0] luma, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(12) : 0;
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {2'b0, luma, fr, h, w};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [8:0] val);
      csr_wen <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_all(input logic [8:0] fx, input logic [8:0] fy, input logic [8:0] amp,
                          input logic [8:0] ms, input logic [8:0] ax, input logic [8:0] ay,
                          input logic [8:0] brk);
      drain();
      csr_write(CSR_FREQ_X, fx);
      csr_write(CSR_FREQ_Y, fy);
      csr_write(CSR_AMPLITUDE, amp);
      csr_write(CSR_MIN_SPEED, ms);
      csr_write(CSR_ANGLE_X, ax);
      csr_write(CSR_ANGLE_Y, ay);
      csr_write(CSR_BREAK, brk);
      csr_wen <= 0;
   endtask

   task automatic frame_run(input int npix, input bit gaps);
      logic [12:0] w, h;
      w = ($urandom_range(9) == 0) ? 13'($urandom_range(8191)) : 13'($urandom_range(1, 12));
      h = ($urandom_range(9) == 0) ? 13'($urandom_range(8191)) : 13'($urandom_range(1, 6));
      send_beat(CMD_FRAME, w, h, 12'($urandom), 8'($urandom), gaps);
      for (int i = 0; i < npix; i++)
         send_beat(CMD_PIXEL, 13'($urandom), 13'($urandom), 12'($urandom), 8'($urandom), gaps);
   endtask

   initial begin
      int sent;
      bit gaps;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: pixel before any frame, extremes, zero sizes, wrap past slice
      send_beat(CMD_PIXEL, 0, 0, 0, 8'd0, 0);
      send_beat(CMD_PIXEL, 0, 0, 0, 8'd255, 0);
      send_beat(CMD_FRAME, 13'd0, 13'd0, 12'd4095, 8'd0, 0);
      send_beat(CMD_PIXEL, 0, 0, 0, 8'd128, 0);
      send_beat(CMD_PIXEL, 0, 0, 0, 8'd16, 0);
      send_beat(CMD_FRAME, 13'd2, 13'd2, 12'd0, 8'd0, 0);
      for (int i = 0; i < 6; i++) send_beat(CMD_PIXEL, 0, 0, 0, 8'(i * 51), 0);
      set_all(100, 100, 45, 100, 360, 360, 500);
      send_beat(CMD_FRAME, 13'd4096, 13'd4096, 12'd4095, 8'd0, 0);
      for (int i = 0; i < 4; i++) send_beat(CMD_PIXEL, 0, 0, 0, i[0] ? 8'd255 : 8'd0, 0);
      set_all(0, 1, 0, 0, 0, 0, 0);
      send_beat(CMD_FRAME, 13'd8191, 13'd8191, 12'd0, 8'd0, 0);
      send_beat(CMD_PIXEL, 0, 0, 0, 8'd255, 0);
      set_all(127, 127, 63, 127, 511, 511, 511);
      send_beat(CMD_FRAME, 13'd3, 13'd1, 12'd100, 8'd0, 0);
      for (int i = 0; i < 4; i++) send_beat(CMD_PIXEL, 0, 0, 0, 8'($urandom), 0);
      // random phases
      sent = 0;
      while (sent < 1500) begin
         if ($urandom_range(3) == 0)
            set_all(9'($urandom_range(100)), 9'($urandom_range(1, 100)),
                    9'($urandom_range(45)), 9'($urandom_range(100)),
                    9'($urandom_range(360)), 9'($urandom_range(360)),
                    9'($urandom_range(1, 500)));
         gaps = $urandom_range(2) != 0;
         for (int f = 0; f < 4; f++) begin
            frame_run($urandom_range(1, 30), gaps);
            sent += 16;
         end
      end
      drain();
      if (fail_count == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end
endmodule
